### rtl/core/text_console_writer_assert.svh
// Assertion macros used by the text console writer back end.
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TCW_ASSERT_NOW(label, cond_a, cond_b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond_a) |-> (cond_b)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TCW_ASSERT_NEXT(label, cond_a, cond_b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond_a) |=> (cond_b)) \
    else $error(msg);

`endif

### rtl/core/tcw_pkg.sv
// Types and constants of the text console writer.
package tcw_pkg;

  localparam int ADDR_W = 13;
  localparam int LOC_W = 11;
  localparam int CELL_W = 16;

  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

  localparam logic [1:0] MODE_PUT = 2'd0;
  localparam logic [1:0] MODE_CLEAR = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;

  localparam logic [7:0] CH_BS = 8'h08;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_FIRST = 8'h20;
  localparam logic [7:0] CH_LAST = 8'h7F;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_PUT,
    OP_CLEAR,
    OP_READ
  } op_t;

  typedef struct packed {
    op_t               op;
    logic              we;
    logic              scroll;
    logic [ADDR_W-1:0] addr;
    logic [CELL_W-1:0] wdata;
    logic [LOC_W-1:0]  loc;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_COPY,
    ST_FILL,
    ST_CLEAR
  } back_state_t;

endpackage

### rtl/core/tcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  parameter int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/tcw_front.sv
// Front end: accepts words, tracks the cursor and classifies each word into a command.
module tcw_front #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [1:0]       mode,
  input  logic [7:0]       char_byte,
  input  logic [3:0]       bg_color,
  input  logic [3:0]       fg_color,
  input  logic [10:0]      cell_index,
  output tcw_pkg::cmd_t    cmd
);

  localparam int CW = $clog2(COLS + 4);
  localparam int RW = $clog2(ROWS + 1);
  localparam int CELLS = ROWS * COLS;
  localparam int IW = tcw_pkg::ADDR_W + 1;

  logic [CW-1:0] col;
  logic [CW-1:0] col_next;
  logic [RW-1:0] row;
  logic [RW-1:0] row_next;

  always_comb begin
    logic [CW-1:0] col_w;
    logic [RW-1:0] row_w;
    col_w = col;
    row_w = row;
    cmd.op = tcw_pkg::OP_NONE;
    cmd.we = 1'b0;
    cmd.scroll = 1'b0;
    cmd.addr = tcw_pkg::ADDR_W'(int'(row) * COLS + int'(col));
    cmd.wdata = {bg_color, fg_color, char_byte};
    case (mode)
      tcw_pkg::MODE_PUT: begin
        cmd.op = tcw_pkg::OP_PUT;
        if (char_byte == tcw_pkg::CH_BS && col != '0) begin
          col_w = col - CW'(1);
        end else if (char_byte == tcw_pkg::CH_TAB) begin
          col_w = (col + CW'(4)) & ~CW'(3);
        end else if (char_byte == tcw_pkg::CH_CR) begin
          col_w = '0;
        end else if (char_byte == tcw_pkg::CH_LF) begin
          col_w = '0;
          row_w = row + RW'(1);
        end else if (char_byte >= tcw_pkg::CH_FIRST && char_byte <= tcw_pkg::CH_LAST) begin
          cmd.we = 1'b1;
          col_w = col + CW'(1);
        end
        if (int'(col_w) >= COLS) begin
          col_w = '0;
          row_w = row_w + RW'(1);
        end
        if (int'(row_w) >= ROWS) begin
          row_w = RW'(ROWS - 1);
          cmd.scroll = 1'b1;
        end
      end
      tcw_pkg::MODE_CLEAR: begin
        cmd.op = tcw_pkg::OP_CLEAR;
        col_w = '0;
        row_w = '0;
      end
      tcw_pkg::MODE_READ: begin
        cmd.addr = tcw_pkg::ADDR_W'(cell_index);
        if ({{(IW - 11){1'b0}}, cell_index} < IW'(CELLS)) begin
          cmd.op = tcw_pkg::OP_READ;
        end
      end
      default: begin
        cmd.op = tcw_pkg::OP_NONE;
      end
    endcase
    col_next = col_w;
    row_next = row_w;
    cmd.loc = tcw_pkg::LOC_W'(int'(row_w) * COLS + int'(col_w));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      col <= col_next;
      row <= row_next;
    end
  end

endmodule

### rtl/core/tcw_queue.sv
// Two-entry command queue between the front end and the back end.
module tcw_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  tcw_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output tcw_pkg::cmd_t head
);

  tcw_pkg::cmd_t entries [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;

  assign full = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10: count <= count + 2'd1;
        2'b01: count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/core/tcw_back.sv
// Back end: carries out commands on the screen memory and issues the result words.
`include "text_console_writer_assert.svh"

module tcw_back #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  tcw_pkg::cmd_t q_head,
  output logic          q_pop,
  output logic          init_busy,
  output logic          res_valid,
  output logic [15:0]   res_data,
  output logic [10:0]   res_loc,
  output logic          res_scrolled
);

  localparam int CELLS = ROWS * COLS;
  localparam int AW = $clog2(CELLS);
  localparam int COPY_N = (ROWS - 1) * COLS;

  tcw_pkg::back_state_t state;
  tcw_pkg::back_state_t state_next;
  logic [AW-1:0]        cnt;
  logic [AW-1:0]        cnt_next;
  logic [10:0]          cur_loc;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [15:0]          ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [15:0]          ram_rdata;

  logic                 emit;
  logic [15:0]          emit_data;
  logic [10:0]          emit_loc;
  logic                 emit_scrolled;

  tcw_ram #(
    .WIDTH(16),
    .DEPTH(CELLS),
    .AW(AW)
  ) u_ram (
    .clk(clk),
    .we(ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    case (state)
      tcw_pkg::ST_INIT, tcw_pkg::ST_CLEAR: begin
        if (cnt == AW'(CELLS - 1)) begin
          state_next = tcw_pkg::ST_IDLE;
        end else begin
          cnt_next = cnt + AW'(1);
        end
      end
      tcw_pkg::ST_IDLE: begin
        if (q_valid) begin
          cnt_next = '0;
          case (q_head.op)
            tcw_pkg::OP_PUT: begin
              if (q_head.scroll) begin
                state_next = tcw_pkg::ST_COPY;
              end
            end
            tcw_pkg::OP_READ: state_next = tcw_pkg::ST_READ;
            tcw_pkg::OP_CLEAR: state_next = tcw_pkg::ST_CLEAR;
            default: state_next = tcw_pkg::ST_IDLE;
          endcase
        end
      end
      tcw_pkg::ST_READ: begin
        state_next = tcw_pkg::ST_IDLE;
      end
      tcw_pkg::ST_COPY: begin
        if (cnt == AW'(COPY_N)) begin
          state_next = tcw_pkg::ST_FILL;
        end else begin
          cnt_next = cnt + AW'(1);
        end
      end
      tcw_pkg::ST_FILL: begin
        if (cnt == AW'(CELLS - 1)) begin
          state_next = tcw_pkg::ST_IDLE;
        end else begin
          cnt_next = cnt + AW'(1);
        end
      end
      default: begin
        state_next = tcw_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    q_pop = 1'b0;
    init_busy = (state == tcw_pkg::ST_INIT);
    ram_we = 1'b0;
    ram_waddr = cnt;
    ram_wdata = tcw_pkg::BLANK_CELL;
    ram_raddr = q_head.addr[AW-1:0];
    emit = 1'b0;
    emit_data = '0;
    emit_loc = cur_loc;
    emit_scrolled = 1'b0;
    case (state)
      tcw_pkg::ST_INIT: begin
        ram_we = 1'b1;
      end
      tcw_pkg::ST_CLEAR: begin
        ram_we = 1'b1;
        emit = (cnt == AW'(CELLS - 1));
      end
      tcw_pkg::ST_IDLE: begin
        q_pop = q_valid;
        emit_loc = q_head.loc;
        if (q_valid) begin
          case (q_head.op)
            tcw_pkg::OP_PUT: begin
              ram_we = q_head.we;
              ram_waddr = q_head.addr[AW-1:0];
              ram_wdata = q_head.wdata;
              emit = ~q_head.scroll;
            end
            tcw_pkg::OP_NONE: emit = 1'b1;
            default: emit = 1'b0;
          endcase
        end
      end
      tcw_pkg::ST_READ: begin
        emit = 1'b1;
        emit_data = ram_rdata;
      end
      tcw_pkg::ST_COPY: begin
        ram_raddr = AW'(int'(cnt) + COLS);
        ram_we = (cnt != '0);
        ram_waddr = cnt - AW'(1);
        ram_wdata = ram_rdata;
      end
      tcw_pkg::ST_FILL: begin
        ram_we = 1'b1;
        emit = (cnt == AW'(CELLS - 1));
        emit_scrolled = 1'b1;
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcw_pkg::ST_INIT;
      cnt <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      res_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_loc <= q_head.loc;
    end
    if (emit) begin
      res_data <= emit_data;
      res_loc <= emit_loc;
      res_scrolled <= emit_scrolled;
    end
  end

  `TCW_ASSERT_NEXT(a_read_emits, state == tcw_pkg::ST_READ, res_valid, "read gave no result")
  `TCW_ASSERT_NEXT(a_init_silent, state == tcw_pkg::ST_INIT, !res_valid, "result during init")
  `TCW_ASSERT_NOW(a_copy_bound, state == tcw_pkg::ST_COPY, cnt <= AW'(COPY_N), "copy overrun")
  `TCW_ASSERT_NOW(a_fill_bottom, state == tcw_pkg::ST_FILL,
                  cnt >= AW'(COPY_N) && cnt <= AW'(CELLS - 1), "fill outside bottom row")

endmodule

### rtl/core/text_console_writer.sv
// Top level of the text console writer: front end, command queue and back end.
//
// A word is taken when start is high and busy is low; each word gives exactly one result,
// shown for one cycle with done high, in the order the words were taken, and the receiver
// must capture it in that cycle. After reset the back end blanks all ROWS*COLS cells, one
// cell a cycle, and busy stays high for that pass. A printable or control byte that does
// not scroll passes through the queue and the single write port of the screen memory; a
// cell read waits in ST_READ for the registered read data. A scroll copies each row up
// through the one read and one write port, and a clear writes ROWS*COLS cells.
// The two-entry queue lets two more words be taken while such a sweep runs.
module text_console_writer #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode,
  input  logic [7:0]  char_byte,
  input  logic [3:0]  bg_color,
  input  logic [3:0]  fg_color,
  input  logic [10:0] cell_index,
  output logic        done,
  output logic [15:0] cell_data,
  output logic [10:0] cursor_pos,
  output logic        scrolled
);

  tcw_pkg::cmd_t front_cmd;
  tcw_pkg::cmd_t q_head;
  logic          accept;
  logic          q_full;
  logic          q_valid;
  logic          q_pop;
  logic          init_busy;

  assign busy = q_full | init_busy;
  assign accept = start & ~busy;

  tcw_front #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .accept(accept),
    .mode(mode),
    .char_byte(char_byte),
    .bg_color(bg_color),
    .fg_color(fg_color),
    .cell_index(cell_index),
    .cmd(front_cmd)
  );

  tcw_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(accept),
    .push_cmd(front_cmd),
    .full(q_full),
    .pop(q_pop),
    .valid(q_valid),
    .head(q_head)
  );

  tcw_back #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .q_valid(q_valid),
    .q_head(q_head),
    .q_pop(q_pop),
    .init_busy(init_busy),
    .res_valid(done),
    .res_data(cell_data),
    .res_loc(cursor_pos),
    .res_scrolled(scrolled)
  );

endmodule

### dv/text_console_checker.sv
// Checker for the text console writer: predicts each result and compares it with the block.
module text_console_checker #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  mode,
  input  logic [7:0]  char_byte,
  input  logic [3:0]  bg_color,
  input  logic [3:0]  fg_color,
  input  logic [10:0] cell_index,
  input  logic        done,
  input  logic [15:0] cell_data,
  input  logic [10:0] cursor_pos,
  input  logic        scrolled,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CELLS = ROWS * COLS;

  typedef struct packed {
    logic [tcw_pkg::CELL_W-1:0] cell_data;
    logic [tcw_pkg::LOC_W-1:0]  loc;
    logic                       scrolled;
  } console_result_t;

  logic [tcw_pkg::CELL_W-1:0] screen [CELLS];
  int unsigned cur_col;
  int unsigned cur_row;
  console_result_t due_results [$];

  function automatic void home_and_blank();
    for (int i = 0; i < CELLS; i++) screen[i] = tcw_pkg::BLANK_CELL;
    cur_col = 0;
    cur_row = 0;
  endfunction

  function automatic console_result_t advance_console(logic [1:0] md, logic [7:0] ch,
                                                      logic [3:0] bc, logic [3:0] fc,
                                                      logic [10:0] idx);
    console_result_t r;
    int i;
    r = '0;
    case (md)
      tcw_pkg::MODE_PUT: begin
        if (ch == tcw_pkg::CH_BS && cur_col != 0) begin
          cur_col--;
        end else if (ch == tcw_pkg::CH_TAB) begin
          cur_col = (cur_col + 4) & ~32'd3;
        end else if (ch == tcw_pkg::CH_CR) begin
          cur_col = 0;
        end else if (ch == tcw_pkg::CH_LF) begin
          cur_col = 0;
          cur_row++;
        end else if (ch >= tcw_pkg::CH_FIRST && ch <= tcw_pkg::CH_LAST) begin
          screen[cur_row * COLS + cur_col] = {bc, fc, ch};
          cur_col++;
        end
        if (cur_col >= COLS) begin
          cur_col = 0;
          cur_row++;
        end
        if (cur_row >= ROWS) begin
          for (i = 0; i < (ROWS - 1) * COLS; i++) screen[i] = screen[i + COLS];
          for (; i < CELLS; i++) screen[i] = tcw_pkg::BLANK_CELL;
          cur_row = ROWS - 1;
          r.scrolled = 1'b1;
        end
      end
      tcw_pkg::MODE_CLEAR: begin
        home_and_blank();
      end
      tcw_pkg::MODE_READ: begin
        if (idx < CELLS) r.cell_data = screen[idx];
      end
      default: begin
      end
    endcase
    r.loc = tcw_pkg::LOC_W'(cur_row * COLS + cur_col);
    return r;
  endfunction

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    console_result_t want;
    if (rst) begin
      home_and_blank();
      due_results.delete();
    end else begin
      if (done) begin
        if (due_results.size() == 0) begin
          $error("result with no word waiting: cell_data %h cursor_pos %0d scrolled %0b",
                 cell_data, cursor_pos, scrolled);
          fail_count++;
        end else begin
          want = due_results.pop_front();
          if (cell_data !== want.cell_data) begin
            $error("cell_data: expected %h, got %h", want.cell_data, cell_data);
            fail_count++;
          end
          if (cursor_pos !== want.loc) begin
            $error("cursor_pos: expected %0d, got %0d", want.loc, cursor_pos);
            fail_count++;
          end
          if (scrolled !== want.scrolled) begin
            $error("scrolled: expected %0b, got %0b", want.scrolled, scrolled);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        due_results.push_back(advance_console(mode, char_byte, bg_color, fg_color,
                                              cell_index));
      end
    end
    pending <= due_results.size();
  end

endmodule

### dv/tb_text_console_writer.sv
// Testbench top for the text console writer: stimulus, watchdog and verdict.
module tb_text_console_writer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROWS = 25;
  localparam int COLS = 80;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int RANDOM_WORDS = 1030;
  localparam int QUIET_TAIL = 150;
  localparam int STALL_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  mode;
  logic [7:0]  char_byte;
  logic [3:0]  bg_color;
  logic [3:0]  fg_color;
  logic [10:0] cell_index;
  logic        done;
  logic [15:0] cell_data;
  logic [10:0] cursor_pos;
  logic        scrolled;
  int          fail_count;
  int          pending;
  int          stall_cycles = 0;

  text_console_writer #(.ROWS(ROWS), .COLS(COLS)) DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode),
    .char_byte(char_byte), .bg_color(bg_color), .fg_color(fg_color),
    .cell_index(cell_index), .done(done), .cell_data(cell_data),
    .cursor_pos(cursor_pos), .scrolled(scrolled)
  );

  text_console_checker #(.ROWS(ROWS), .COLS(COLS)) u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode),
    .char_byte(char_byte), .bg_color(bg_color), .fg_color(fg_color),
    .cell_index(cell_index), .done(done), .cell_data(cell_data),
    .cursor_pos(cursor_pos), .scrolled(scrolled),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_word(input logic [1:0] md, input logic [7:0] ch, input logic [3:0] bc,
                           input logic [3:0] fc, input logic [10:0] idx);
    mode <= md;
    char_byte <= ch;
    bg_color <= bc;
    fg_color <= fc;
    cell_index <= idx;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    logic [1:0]  md;
    logic [7:0]  ch;
    logic [10:0] idx;
    int          pick;
    bit          gaps_on;
    rst <= 1'b1;
    start <= 1'b0;
    mode <= tcw_pkg::MODE_PUT;
    char_byte <= '0;
    bg_color <= '0;
    fg_color <= '0;
    cell_index <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_word(tcw_pkg::MODE_READ, 8'h00, 4'h0, 4'h0, 11'd0);
    send_word(tcw_pkg::MODE_READ, 8'hFF, 4'hF, 4'hF, 11'd1999);
    send_word(tcw_pkg::MODE_READ, 8'h00, 4'h0, 4'h0, 11'd2000);
    send_word(tcw_pkg::MODE_READ, 8'hFF, 4'hF, 4'hF, 11'd2047);
    send_word(tcw_pkg::MODE_PUT, tcw_pkg::CH_FIRST, 4'h0, 4'h0, 11'd0);
    send_word(tcw_pkg::MODE_PUT, tcw_pkg::CH_LAST, 4'hF, 4'hF, 11'd2047);
    send_word(tcw_pkg::MODE_PUT, 8'h1F, 4'h3, 4'hC, 11'd0);
    send_word(tcw_pkg::MODE_PUT, 8'h80, 4'hA, 4'h5, 11'd0);
    send_word(tcw_pkg::MODE_PUT, 8'hFF, 4'hF, 4'hF, 11'd0);
    send_word(tcw_pkg::MODE_PUT, 8'h00, 4'h0, 4'h0, 11'd0);
    send_word(tcw_pkg::MODE_PUT, tcw_pkg::CH_BS, 4'h0, 4'h0, 11'd0);
    send_word(tcw_pkg::MODE_PUT, tcw_pkg::CH_BS, 4'h0, 4'h0, 11'd0);
    send_word(tcw_pkg::MODE_PUT, tcw_pkg::CH_BS, 4'h0, 4'h0, 11'd0);
    send_word(tcw_pkg::MODE_PUT, tcw_pkg::CH_TAB, 4'h0, 4'h0, 11'd0);
    send_word(tcw_pkg::MODE_PUT, 8'h41, 4'h1, 4'hE, 11'd0);
    send_word(tcw_pkg::MODE_PUT, tcw_pkg::CH_TAB, 4'h0, 4'h0, 11'd0);
    send_word(tcw_pkg::MODE_PUT, tcw_pkg::CH_CR, 4'h0, 4'h0, 11'd0);
    send_word(tcw_pkg::MODE_PUT, tcw_pkg::CH_LF, 4'h0, 4'h0, 11'd0);
    send_word(tcw_pkg::MODE_READ, 8'h00, 4'h0, 4'h0, 11'd0);
    send_word(tcw_pkg::MODE_READ, 8'h00, 4'h0, 4'h0, 11'd1);
    send_word(tcw_pkg::MODE_READ, 8'h00, 4'h0, 4'h0, 11'd4);
    send_word(MODE_UNUSED, 8'h41, 4'hF, 4'hF, 11'd4);
    send_word(tcw_pkg::MODE_CLEAR, 8'h41, 4'hF, 4'hF, 11'd4);
    send_word(tcw_pkg::MODE_READ, 8'h00, 4'h0, 4'h0, 11'd1);
    drain_results();

    gaps_on = 1'b1;
    for (int k = 0; k < RANDOM_WORDS; k++) begin
      if (k % 64 == 0) gaps_on = ($urandom_range(0, 2) != 0);
      if (k == RANDOM_WORDS / 2) drain_results();
      md = tcw_pkg::MODE_PUT;
      ch = 8'($urandom_range(8'h20, 8'h7F));
      idx = 11'($urandom_range(0, 2047));
      pick = $urandom_range(0, 199);
      if ($urandom_range(0, 299) == 0) begin
        md = tcw_pkg::MODE_CLEAR;
      end else if (pick < 3) begin
        md = MODE_UNUSED;
      end else if (pick < 33) begin
        md = tcw_pkg::MODE_READ;
        case ($urandom_range(0, 3))
          0: idx = 11'($urandom_range(0, 2 * COLS - 1));
          1: idx = 11'($urandom_range((ROWS - 2) * COLS, ROWS * COLS - 1));
          default: begin
          end
        endcase
      end else if (pick < 47) begin
        ch = tcw_pkg::CH_LF;
      end else if (pick < 53) begin
        ch = tcw_pkg::CH_CR;
      end else if (pick < 59) begin
        ch = tcw_pkg::CH_BS;
      end else if (pick < 67) begin
        ch = tcw_pkg::CH_TAB;
      end else if (pick < 77) begin
        ch = 8'($urandom_range(0, 255));
      end
      if (md != tcw_pkg::MODE_PUT && $urandom_range(0, 1) == 1) begin
        ch = 8'($urandom_range(0, 255));
      end
      send_word(md, ch, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), idx);
      if (k < RANDOM_WORDS - QUIET_TAIL && gaps_on && $urandom_range(0, 3) == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
